[hdl/ast_pkg.sv]
`timescale 1ns / 1ps

package ast_pkg;

    localparam int DEFAULT_POSITION_BITS = 16;
    localparam int RES_SLOTS   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_buffer;
    } ast_in_t;

    typedef struct packed {
        logic        event_res;
        logic [3:0]  tok_kind;
        logic [7:0]  char_value;
        logic        appended;
        logic [15:0] token_start;
        logic        lex_error;
        logic        last_of_run;
    } ast_res_t;

    // All results caused by one input byte, in order.
    typedef struct packed {
        ast_res_t [RES_SLOTS-1:0] res;
        logic [1:0]               cnt;
    } ast_bundle_t;

    function automatic ast_res_t mk_res(input logic ev, input logic [3:0] tt,
                                        input logic [7:0] ch, input logic app,
                                        input logic [15:0] start, input logic err);
        ast_res_t r;
        r.event_res   = ev;
        r.tok_kind    = tt;
        r.char_value  = ch;
        r.appended    = app;
        r.token_start = start;
        r.lex_error   = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

[hdl/ast_front.sv]
`timescale 1ns / 1ps

module ast_front #(
    parameter int POSITION_BITS = ast_pkg::DEFAULT_POSITION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  ast_pkg::ast_in_t    din,
    output logic                wr,
    output ast_pkg::ast_bundle_t wr_data
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_COMMENT
    } mode_t;

    localparam logic [3:0] TT_PLUS    = 4'd0;
    localparam logic [3:0] TT_MINUS   = 4'd1;
    localparam logic [3:0] TT_COMMA   = 4'd2;
    localparam logic [3:0] TT_NUMERAL = 4'd3;
    localparam logic [3:0] TT_COLON   = 4'd4;
    localparam logic [3:0] TT_CIRC    = 4'd5;
    localparam logic [3:0] TT_NEWLINE = 4'd6;
    localparam logic [3:0] TT_BAR     = 4'd7;
    localparam logic [3:0] TT_LESS    = 4'd8;
    localparam logic [3:0] TT_GREATER = 4'd9;
    localparam logic [3:0] TT_IDENT   = 4'd10;
    localparam logic [3:0] TT_NUMBER  = 4'd11;
    localparam logic [3:0] TT_COMMENT = 4'd12;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    // Returns a valid flag above the four bit operator type.
    function automatic logic [4:0] op_code(input logic [7:0] c);
        logic [4:0] r;
        case (c)
            8'h2B:   r = {1'b1, TT_PLUS};
            8'h2D:   r = {1'b1, TT_MINUS};
            8'h2C:   r = {1'b1, TT_COMMA};
            8'h23:   r = {1'b1, TT_NUMERAL};
            8'h3A:   r = {1'b1, TT_COLON};
            8'h5E:   r = {1'b1, TT_CIRC};
            CH_LF:   r = {1'b1, TT_NEWLINE};
            CH_CR:   r = {1'b1, TT_NEWLINE};
            8'h7C:   r = {1'b1, TT_BAR};
            8'h3C:   r = {1'b1, TT_LESS};
            8'h3E:   r = {1'b1, TT_GREATER};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] mode_type(input mode_t m);
        logic [3:0] r;
        case (m)
            MODE_IDENT:  r = TT_IDENT;
            MODE_NUMBER: r = TT_NUMBER;
            default:     r = TT_COMMENT;
        endcase
        return r;
    endfunction

    mode_t                    mode_reg, mode_next;
    logic [15:0]              ostart_reg, ostart_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic [31:0]          pos_wide;
    logic [15:0]          p16;
    logic [7:0]           c;
    logic [4:0]           op;
    logic                 cont;
    logic [1:0]           n;
    ast_pkg::ast_bundle_t bun;

    assign c        = din.char_byte;
    assign op       = op_code(c);
    assign pos_wide = 32'(pos_reg);
    assign p16      = pos_wide[15:0];

    always_comb
    begin
        mode_next   = mode_reg;
        ostart_next = ostart_reg;
        cont        = 1'b0;
        n           = 2'd0;
        bun         = '0;

        case (mode_reg)
            MODE_IDENT:
            begin
                if (is_letter(c) || is_digit(c) || c == CH_UNDER)
                begin
                    bun.res[n] = ast_pkg::mk_res(1'b0, TT_IDENT, c, 1'b1, ostart_reg, 1'b0);
                    n    = n + 2'd1;
                    cont = 1'b1;
                end
                else
                begin
                    bun.res[n] = ast_pkg::mk_res(1'b1, TT_IDENT, 8'd0, 1'b0, ostart_reg, 1'b0);
                    n         = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUMBER:
            begin
                if (c == CH_DOT || c == CH_LOW_X || c == CH_UP_X || c == CH_UNDER
                    || is_digit(c) || is_hex_letter(c))
                begin
                    bun.res[n] = ast_pkg::mk_res(1'b0, TT_NUMBER, c, c != CH_UNDER,
                                                 ostart_reg, 1'b0);
                    n    = n + 2'd1;
                    cont = 1'b1;
                end
                else
                begin
                    bun.res[n] = ast_pkg::mk_res(1'b1, TT_NUMBER, 8'd0, 1'b0, ostart_reg, 1'b0);
                    n         = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_COMMENT:
            begin
                if (!is_newline(c))
                begin
                    bun.res[n] = ast_pkg::mk_res(1'b0, TT_COMMENT, c, 1'b1, ostart_reg, 1'b0);
                    n    = n + 2'd1;
                    cont = 1'b1;
                end
                else
                begin
                    bun.res[n] = ast_pkg::mk_res(1'b1, TT_COMMENT, 8'd0, 1'b0, ostart_reg, 1'b0);
                    n         = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (!cont)
        begin
            if (c == CH_SPACE || c == CH_TAB)
            begin
            end
            else if (c == CH_SEMI)
            begin
                ostart_next = p16;
                mode_next   = MODE_COMMENT;
                bun.res[n]  = ast_pkg::mk_res(1'b0, TT_COMMENT, c, 1'b0, p16, 1'b0);
                n           = n + 2'd1;
            end
            else if (op[4])
            begin
                bun.res[n] = ast_pkg::mk_res(1'b0, op[3:0], c, 1'b1, p16, 1'b0);
                n          = n + 2'd1;
                bun.res[n] = ast_pkg::mk_res(1'b1, op[3:0], 8'd0, 1'b0, p16, 1'b0);
                n          = n + 2'd1;
            end
            else if (is_letter(c) || c == CH_UNDER)
            begin
                ostart_next = p16;
                mode_next   = MODE_IDENT;
                bun.res[n]  = ast_pkg::mk_res(1'b0, TT_IDENT, c, 1'b1, p16, 1'b0);
                n           = n + 2'd1;
            end
            else if (is_digit(c) || c == CH_DOT || c == CH_DOLLAR || c == CH_PCT)
            begin
                ostart_next = p16;
                mode_next   = MODE_NUMBER;
                bun.res[n]  = ast_pkg::mk_res(1'b0, TT_NUMBER, c, 1'b1, p16, 1'b0);
                n           = n + 2'd1;
            end
            else
            begin
                bun.res[n] = ast_pkg::mk_res(1'b0, TT_PLUS, c, 1'b0, p16, 1'b1);
                n          = n + 2'd1;
            end
        end

        if (din.end_of_buffer)
        begin
            if (mode_next != MODE_IDLE)
            begin
                bun.res[n] = ast_pkg::mk_res(1'b1, mode_type(mode_next), 8'd0, 1'b0,
                                             ostart_next, 1'b0);
                n = n + 2'd1;
            end
            mode_next = MODE_IDLE;
            pos_next  = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end

        bun.cnt = n;
    end

    assign wr      = take && (bun.cnt != 2'd0);
    assign wr_data = bun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            ostart_reg <= '0;
            pos_reg    <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            ostart_reg <= ostart_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

[hdl/ast_queue.sv]
`timescale 1ns / 1ps

module ast_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  ast_pkg::ast_bundle_t wr_data,
    input  logic                 rd,
    output ast_pkg::ast_bundle_t rd_data,
    output logic                 full,
    output logic                 avail
);

    localparam int AW = ast_pkg::QUEUE_AW;

    ast_pkg::ast_bundle_t store_reg [ast_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full    = cnt_reg == (AW + 1)'(ast_pkg::QUEUE_DEPTH);
    assign avail   = cnt_reg != '0;
    assign rd_data = store_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (AW + 1)'(wr) - (AW + 1)'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            store_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW + 1)'(ast_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("write into a full queue");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && !avail))
        else $error("read from an empty queue");

endmodule

[hdl/ast_back.sv]
`timescale 1ns / 1ps

module ast_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_avail,
    input  ast_pkg::ast_bundle_t q_data,
    output logic                 q_rd,
    input  logic                 pop,
    output logic                 empty,
    output ast_pkg::ast_res_t    dout
);

    ast_pkg::ast_bundle_t bun_reg;
    logic                 bun_valid_reg;
    logic [1:0]           idx_reg;
    ast_pkg::ast_res_t    out_reg;
    logic                 out_valid_reg;

    logic              out_load;
    logic              step;
    logic              bun_last;
    ast_pkg::ast_res_t cur;

    assign out_load = !out_valid_reg || pop;
    assign step     = bun_valid_reg && out_load;
    assign bun_last = idx_reg == (bun_reg.cnt - 2'd1);
    assign q_rd     = q_avail && (!bun_valid_reg || (step && bun_last));

    always_comb
    begin
        cur             = bun_reg.res[idx_reg];
        cur.last_of_run = bun_last;
    end

    assign empty = !out_valid_reg;
    assign dout  = out_reg;

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            bun_reg <= q_data;
        end
        if (step)
        begin
            out_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bun_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_rd)
            begin
                bun_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (step && bun_last)
            begin
                bun_valid_reg <= 1'b0;
            end
            else if (step)
            begin
                idx_reg <= idx_reg + 2'd1;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_bundle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        bun_valid_reg |-> (bun_reg.cnt != 2'd0))
        else $error("empty result group held for output");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bun_valid_reg |-> (idx_reg < bun_reg.cnt))
        else $error("result index beyond group size");

endmodule

[hdl/assembly_source_tokenizer.sv]
`timescale 1ns / 1ps

// Streaming tokenizer for assembler source text.
// Input channel: a word is one source byte with its end-of-buffer mark, taken
// on a rising edge with push high and full low. The classifier handles one
// byte per cycle while full is low and writes each byte's results, if there
// are any, as one group into a four-deep queue.
// Result channel: while empty is low the oldest word is on dout; pop takes it.
// Each byte yields zero to three words, the last of them flagged last_of_run.
// A byte's words pass through the queue, a group register and the output register to dout.
// Throughput is one byte per cycle while each byte yields at most one word and
// pop stays high, and one word per cycle on the result side while pop stays high,
// which sets the byte rate for bytes that close one token and open another.
// When the receiver stalls, the output register and the queue fill and full
// rises; the front keeps taking bytes until the queue has no room.
// Reset clears the scanner to idle, the byte position to zero and empties
// the queue and the output register.
module assembly_source_tokenizer #(
    parameter int POSITION_BITS = ast_pkg::DEFAULT_POSITION_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ast_pkg::ast_in_t  din,
    input  logic              pop,
    output logic              empty,
    output ast_pkg::ast_res_t dout
);

    logic                 take;
    logic                 q_wr;
    logic                 q_rd;
    logic                 q_full;
    logic                 q_avail;
    ast_pkg::ast_bundle_t q_wdata;
    ast_pkg::ast_bundle_t q_rdata;

    assign full = q_full;
    assign take = push && !q_full;

    ast_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .din    (din),
        .wr     (q_wr),
        .wr_data(q_wdata)
    );

    ast_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_data(q_wdata),
        .rd     (q_rd),
        .rd_data(q_rdata),
        .full   (q_full),
        .avail  (q_avail)
    );

    ast_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_avail(q_avail),
        .q_data (q_rdata),
        .q_rd   (q_rd),
        .pop    (pop),
        .empty  (empty),
        .dout   (dout)
    );

endmodule

[verif/token_event_checker.sv]
`timescale 1ns / 1ps

module token_event_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  ast_pkg::ast_in_t           din,
    input  logic                       pop,
    input  logic                       empty,
    input  ast_pkg::ast_res_t          dout,
    output int unsigned                mismatches,
    output int unsigned                outstanding
);

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_COMMENT
    } scan_mode_e;

    localparam logic [3:0] TT_PLUS     = 4'd0;
    localparam logic [3:0] TT_MINUS    = 4'd1;
    localparam logic [3:0] TT_COMMA    = 4'd2;
    localparam logic [3:0] TT_HASH     = 4'd3;
    localparam logic [3:0] TT_COLON    = 4'd4;
    localparam logic [3:0] TT_CARET    = 4'd5;
    localparam logic [3:0] TT_NEWLINE  = 4'd6;
    localparam logic [3:0] TT_BAR      = 4'd7;
    localparam logic [3:0] TT_LESS     = 4'd8;
    localparam logic [3:0] TT_GREATER  = 4'd9;
    localparam logic [3:0] TT_IDENT    = 4'd10;
    localparam logic [3:0] TT_NUMBER   = 4'd11;
    localparam logic [3:0] TT_COMMENT  = 4'd12;
    localparam logic [3:0] TT_ON_ERROR = 4'd0;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    scan_mode_e        mode          = SCAN_IDLE;
    logic [15:0]       open_start    = '0;
    logic [15:0]       position      = '0;
    ast_pkg::ast_res_t expected_events[$];
    int unsigned       fail_total    = 0;
    int unsigned       pending_count = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_count;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hex_letter(input logic [7:0] c);
        return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_newline(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit operator_kind(input logic [7:0] c, output logic [3:0] kind);
        kind = TT_PLUS;
        case (c)
            "+":   kind = TT_PLUS;
            "-":   kind = TT_MINUS;
            ",":   kind = TT_COMMA;
            "#":   kind = TT_HASH;
            ":":   kind = TT_COLON;
            "^":   kind = TT_CARET;
            CH_LF: kind = TT_NEWLINE;
            CH_CR: kind = TT_NEWLINE;
            "|":   kind = TT_BAR;
            "<":   kind = TT_LESS;
            ">":   kind = TT_GREATER;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic [3:0] open_token_type(input scan_mode_e m);
        if (m == SCAN_IDENT)
        begin
            return TT_IDENT;
        end
        if (m == SCAN_NUMBER)
        begin
            return TT_NUMBER;
        end
        return TT_COMMENT;
    endfunction

    function automatic ast_pkg::ast_res_t event_word(input logic ev, input logic [3:0] kind,
                                                     input logic [7:0] ch, input logic app,
                                                     input logic [15:0] start,
                                                     input logic err);
        ast_pkg::ast_res_t w;
        w.event_res   = ev;
        w.tok_kind    = kind;
        w.char_value  = ch;
        w.appended    = app;
        w.token_start = start;
        w.lex_error   = err;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    task automatic predict_events(input ast_pkg::ast_in_t w);
        ast_pkg::ast_res_t run[$];
        logic [7:0]        c;
        logic [15:0]       p;
        logic [3:0]        kind;
        bit                consumed;
        c = w.char_byte;
        p = position;
        consumed = 1'b0;
        case (mode)
            SCAN_IDENT:
            begin
                if (is_letter(c) || is_digit(c) || c == "_")
                begin
                    run.insert(run.size(),
                               event_word(1'b0, TT_IDENT, c, 1'b1, open_start, 1'b0));
                    consumed = 1'b1;
                end
                else
                begin
                    run.insert(run.size(),
                               event_word(1'b1, TT_IDENT, 8'd0, 1'b0, open_start, 1'b0));
                    mode = SCAN_IDLE;
                end
            end
            SCAN_NUMBER:
            begin
                if (c == "." || c == "x" || c == "X" || c == "_" || is_digit(c)
                    || is_hex_letter(c))
                begin
                    run.insert(run.size(),
                               event_word(1'b0, TT_NUMBER, c, c != "_", open_start, 1'b0));
                    consumed = 1'b1;
                end
                else
                begin
                    run.insert(run.size(),
                               event_word(1'b1, TT_NUMBER, 8'd0, 1'b0, open_start, 1'b0));
                    mode = SCAN_IDLE;
                end
            end
            SCAN_COMMENT:
            begin
                if (!is_newline(c))
                begin
                    run.insert(run.size(),
                               event_word(1'b0, TT_COMMENT, c, 1'b1, open_start, 1'b0));
                    consumed = 1'b1;
                end
                else
                begin
                    run.insert(run.size(),
                               event_word(1'b1, TT_COMMENT, 8'd0, 1'b0, open_start, 1'b0));
                    mode = SCAN_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        if (!consumed)
        begin
            if (c == ";")
            begin
                open_start = p;
                mode = SCAN_COMMENT;
                run.insert(run.size(), event_word(1'b0, TT_COMMENT, c, 1'b0, p, 1'b0));
            end
            else if (operator_kind(c, kind))
            begin
                run.insert(run.size(), event_word(1'b0, kind, c, 1'b1, p, 1'b0));
                run.insert(run.size(), event_word(1'b1, kind, 8'd0, 1'b0, p, 1'b0));
            end
            else if (is_letter(c) || c == "_")
            begin
                open_start = p;
                mode = SCAN_IDENT;
                run.insert(run.size(), event_word(1'b0, TT_IDENT, c, 1'b1, p, 1'b0));
            end
            else if (is_digit(c) || c == "." || c == "$" || c == "%")
            begin
                open_start = p;
                mode = SCAN_NUMBER;
                run.insert(run.size(), event_word(1'b0, TT_NUMBER, c, 1'b1, p, 1'b0));
            end
            else if (c != " " && c != CH_TAB)
            begin
                run.insert(run.size(), event_word(1'b0, TT_ON_ERROR, c, 1'b0, p, 1'b1));
            end
        end
        if (w.end_of_buffer)
        begin
            if (mode != SCAN_IDLE)
            begin
                run.insert(run.size(), event_word(1'b1, open_token_type(mode), 8'd0, 1'b0,
                                                  open_start, 1'b0));
            end
            mode = SCAN_IDLE;
            position = '0;
        end
        else
        begin
            position = p + 16'd1;
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].last_of_run = 1'b1;
        end
        foreach (run[i])
        begin
            expected_events.insert(expected_events.size(), run[i]);
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_value,
                               input int unsigned act_value);
        if (exp_value != act_value)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_value, act_value);
            fail_total++;
        end
    endtask

    task automatic compare_word(input ast_pkg::ast_res_t got);
        ast_pkg::ast_res_t want;
        if (expected_events.size() == 0)
        begin
            $error("unexpected word: type %0d, char 0x%0h, start %0d",
                   got.tok_kind, got.char_value, got.token_start);
            fail_total++;
            return;
        end
        want = expected_events.pop_front();
        check_field("event_res", want.event_res, got.event_res);
        check_field("tok_kind", want.tok_kind, got.tok_kind);
        check_field("char_value", want.char_value, got.char_value);
        check_field("appended", want.appended, got.appended);
        check_field("token_start", want.token_start, got.token_start);
        check_field("lex_error", want.lex_error, got.lex_error);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode = SCAN_IDLE;
            open_start = '0;
            position = '0;
            expected_events.delete();
            pending_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                compare_word(dout);
            end
            if (push && !full)
            begin
                predict_events(din);
            end
            pending_count = expected_events.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned PHASE_ITEMS  = 60;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    ast_pkg::ast_in_t  din;
    logic              pop;
    logic              empty;
    ast_pkg::ast_res_t dout;

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    bit          hold_request = 1'b0;

    string ident_head  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string ident_tail  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string number_head = "0123456789.$%";
    string number_tail = "0123456789abcdefABCDEF.xX_";
    string operators   = "+-,#:^|<>\015\012";
    string blanks      = " \t";
    string line_ends   = "\015\012";

    assembly_source_tokenizer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (din),
        .pop   (pop),
        .empty (empty),
        .dout  (dout)
    );

    token_event_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .din         (din),
        .pop         (pop),
        .empty       (empty),
        .dout        (dout),
        .mismatches  (mismatch_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("assembly_source_tokenizer test failed");
            $finish;
        end
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic send_word(input logic [7:0] c, input bit eob);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        din <= '{char_byte: c, end_of_buffer: eob};
        @(negedge clk);
        while (full)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eob_last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], eob_last && (i == s.len() - 1));
        end
    endtask

    function automatic bit random_eob();
        return $urandom_range(99) < 4;
    endfunction

    task automatic send_random_token();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  c;
        pick = $urandom_range(99);
        len = $urandom_range(6);
        if (pick < 25)
        begin
            send_word(pick_from(ident_head), random_eob());
            repeat (len) send_word(pick_from(ident_tail), random_eob());
        end
        else if (pick < 45)
        begin
            send_word(pick_from(number_head), random_eob());
            repeat (len) send_word(pick_from(number_tail), random_eob());
        end
        else if (pick < 55)
        begin
            send_word(";", random_eob());
            repeat (len)
            begin
                c = 8'($urandom_range(255));
                while (c == 8'h0A || c == 8'h0D)
                begin
                    c = 8'($urandom_range(255));
                end
                send_word(c, random_eob());
            end
            if ($urandom_range(99) < 80)
            begin
                send_word(pick_from(line_ends), random_eob());
            end
        end
        else if (pick < 75)
        begin
            send_word(pick_from(operators), random_eob());
        end
        else if (pick < 85)
        begin
            send_word(pick_from(blanks), random_eob());
        end
        else
        begin
            send_word(8'($urandom_range(255)), random_eob());
        end
    endtask

    task automatic send_random_items(input int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            send_random_token();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        din = '0;
        tx_idle_pct = 32;
        rx_idle_pct = 79;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("+-,#:^|<>\015\012", 1'b0);
        send_text("_Z9 ", 1'b0);
        send_text("%_aX.;\t\015", 1'b0);
        send_word(8'hFF, 1'b0);
        send_word("@", 1'b0);
        send_text("q", 1'b1);
        send_text("$", 1'b1);

        send_random_items(PHASE_ITEMS);
        tx_idle_pct = 79;
        rx_idle_pct = 32;
        send_random_items(PHASE_ITEMS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // The receiver stalls for a long stretch here, so the block fills and holds off input.
        hold_request = 1'b1;
        send_random_items(PHASE_ITEMS);
        push <= 1'b0;

        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("assembly_source_tokenizer test passed");
        end
        else
        begin
            $display("assembly_source_tokenizer test failed");
        end
        $finish;
    end

endmodule
